### src/adcb_pkg.sv
// Package for the ATA DMA command builder: sizing constants, request and
// record codes, and the ATA command bytes. No dependencies.
package adcb_pkg;

    // Sizing of the command builder.
    localparam int unsigned MAX_SECTORS     = 256;
    localparam int unsigned PRD_CHUNK_BYTES = 4096;
    localparam int unsigned SLOT_COUNT      = 32;
    localparam int unsigned SECTOR_BYTES    = 512;
    localparam int unsigned PRD_LIMIT       = 32;
    localparam int unsigned IDENTIFY_BYTES  = 512;

    // Derived widths.
    localparam int unsigned CHUNK_SHIFT = $clog2(PRD_CHUNK_BYTES);
    localparam int unsigned BYTES_W     = 16 + $clog2(SECTOR_BYTES) + 2;
    localparam int unsigned CHUNK_W     = CHUNK_SHIFT + 1;

    // Operation codes of a request.
    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_FLUSH    = 2'd2;
    localparam logic [1:0] OP_IDENTIFY = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NO_SLOT   = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // Record kinds.
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_FIS    = 2'd1;
    localparam logic [1:0] KIND_PRD    = 2'd2;

    // FIS and ATA command bytes.
    localparam logic [7:0] FIS_H2D          = 8'h27;
    localparam logic [7:0] FIS_CMD_BIT      = 8'h80;
    localparam logic [7:0] LBA_MODE         = 8'h40;
    localparam logic [7:0] CMD_READ_DMA     = 8'hC8;
    localparam logic [7:0] CMD_WRITE_DMA    = 8'hCA;
    localparam logic [7:0] CMD_READ_DMA_EX  = 8'h25;
    localparam logic [7:0] CMD_WRITE_DMA_EX = 8'h35;
    localparam logic [7:0] CMD_FLUSH_EXT    = 8'hEA;
    localparam logic [7:0] CMD_IDENTIFY     = 8'hEC;
    localparam logic [31:0] FIS_LENGTH_DW   = 32'd5;
    localparam logic [2:0]  FIS_LAST_DW     = 3'd4;

endpackage

### src/ata_dma_command_builder_unit.sv
// Top level of the ATA DMA command builder: turns one disk request into a
// command header, five register FIS dwords and the PRD entries. Uses adcb_pkg.
//
// The first record, the header, is registered and appears in the cycle after
// the request is taken. An accepted request produces 6 + N records on
// consecutive cycles (N PRD entries, at most 32); a rejected request gives
// one status record and the block is free again the next cycle.
// The PRD run is set by the single 64-bit address adder, one entry a cycle.
// Reset (synchronous, active low) returns to idle and clears device_present.
// Records cannot be stalled: each is shown for exactly one cycle.
module ata_dma_command_builder_unit
    import adcb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [47:0] i_lba,
    input  logic [15:0] i_sector_count,
    input  logic [63:0] i_buffer_address,
    input  logic [31:0] i_slots_busy,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [1:0]  o_record_kind,
    output logic [4:0]  o_slot,
    output logic        o_write_flag,
    output logic [5:0]  o_prd_count,
    output logic [31:0] o_fis_dword,
    output logic [63:0] o_prd_address,
    output logic [11:0] o_prd_bytes_minus_one,
    output logic        o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIS,
        S_PRD
    } t_state;

    localparam logic [31:0] SLOT_MASK = (SLOT_COUNT >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << SLOT_COUNT) - 64'd1);
    localparam logic [BYTES_W-1:0] CHUNK_M1 = BYTES_W'(PRD_CHUNK_BYTES - 1);

    t_state      r_state;
    logic        r_device_present;
    logic [2:0]  r_fis_idx;
    logic [5:0]  r_prd_idx;
    logic [1:0]  r_op;
    logic [47:0] r_lba;
    logic [15:0] r_count;
    logic [63:0] r_addr;
    logic [BYTES_W-1:0] r_bytes;

    logic        r_strobe;
    logic [1:0]  r_status;
    logic [1:0]  r_kind;
    logic [4:0]  r_slot;
    logic        r_write_flag;
    logic [5:0]  r_prd_count;
    logic [31:0] r_fis_dword;
    logic [63:0] r_prd_address;
    logic [11:0] r_bm1;
    logic        r_last;

    // Request checks taken from the input ports and the device_present flag.
    logic               n_rw;
    logic               n_has_data;
    logic [BYTES_W-1:0] n_bytes;
    logic [BYTES_W-1:0] n_prds;
    logic               n_err_invalid;
    logic               n_err_large;
    logic               n_err_slot;
    logic [31:0]        n_free;
    logic [31:0]        n_first_free;
    logic [4:0]         n_slot;

    always_comb begin
        n_rw          = (i_operation == OP_READ) || (i_operation == OP_WRITE);
        n_err_invalid = n_rw && (!r_device_present || (i_buffer_address == 64'd0));
        n_has_data    = (i_buffer_address != 64'd0)
                        && ((n_rw && (i_sector_count != 16'd0))
                            || (i_operation == OP_IDENTIFY));
        if (!n_has_data) begin
            n_bytes = '0;
        end else if (i_operation == OP_IDENTIFY) begin
            n_bytes = BYTES_W'(IDENTIFY_BYTES);
        end else begin
            n_bytes = BYTES_W'(i_sector_count) * BYTES_W'(SECTOR_BYTES);
        end
        n_prds      = (n_bytes + CHUNK_M1) >> CHUNK_SHIFT;
        n_err_large = (n_rw && (32'(i_sector_count) > 32'(MAX_SECTORS)))
                      || (n_prds > BYTES_W'(PRD_LIMIT));
        // Lowest free slot: isolate the lowest set bit, then encode it.
        n_free       = ~i_slots_busy & SLOT_MASK;
        n_first_free = n_free & (~n_free + 32'd1);
        n_err_slot   = (n_free == 32'd0);
        n_slot       = 5'd0;
        for (int j = 0; j < 32; j++) begin
            if (n_first_free[j]) begin
                n_slot = n_slot | 5'(j);
            end
        end
    end

    // FIS dword selection from the latched request.
    logic        n_small;
    logic        n_lrw;
    logic [7:0]  n_cmd;
    logic [31:0] n_dword;

    always_comb begin
        n_lrw   = (r_op == OP_READ) || (r_op == OP_WRITE);
        n_small = (r_lba[47:28] == 20'd0) && (r_count <= 16'd256);
        if (n_lrw) begin
            if (n_small) begin
                n_cmd = (r_op == OP_WRITE) ? CMD_WRITE_DMA : CMD_READ_DMA;
            end else begin
                n_cmd = (r_op == OP_WRITE) ? CMD_WRITE_DMA_EX : CMD_READ_DMA_EX;
            end
        end else begin
            n_cmd = (r_op == OP_FLUSH) ? CMD_FLUSH_EXT : CMD_IDENTIFY;
        end
        case (r_fis_idx)
            3'd0: n_dword = {8'h00, n_cmd, FIS_CMD_BIT, FIS_H2D};
            3'd1: begin
                if (!n_lrw) begin
                    n_dword = 32'd0;
                end else if (n_small) begin
                    n_dword = {LBA_MODE | {4'h0, r_lba[27:24]}, r_lba[23:0]};
                end else begin
                    n_dword = {LBA_MODE, r_lba[23:0]};
                end
            end
            3'd2: n_dword = (n_lrw && !n_small) ? {8'h00, r_lba[47:24]} : 32'd0;
            3'd3: begin
                if (!n_lrw) begin
                    n_dword = 32'd0;
                end else if (n_small) begin
                    n_dword = {24'd0, r_count[7:0]};
                end else begin
                    n_dword = {16'd0, r_count};
                end
            end
            default: n_dword = 32'd0;
        endcase
    end

    // Sequencer, the single address adder and registered record outputs.
    logic n_prd_last;
    assign n_prd_last = (r_prd_idx == r_prd_count - 6'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_strobe         <= 1'b0;
            r_device_present <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_device_present <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_strobe      <= 1'b1;
                        r_kind        <= KIND_HEADER;
                        r_fis_dword   <= 32'd0;
                        r_prd_address <= 64'd0;
                        r_bm1         <= 12'd0;
                        r_op          <= i_operation;
                        r_lba         <= i_lba;
                        r_count       <= i_sector_count;
                        r_addr        <= i_buffer_address;
                        r_bytes       <= n_bytes;
                        r_fis_idx     <= 3'd0;
                        r_prd_idx     <= 6'd0;
                        if (n_err_invalid || n_err_large || n_err_slot) begin
                            if (n_err_invalid) begin
                                r_status <= ST_INVALID;
                            end else if (n_err_large) begin
                                r_status <= ST_TOO_LARGE;
                            end else begin
                                r_status <= ST_NO_SLOT;
                            end
                            r_slot       <= 5'd0;
                            r_write_flag <= 1'b0;
                            r_prd_count  <= 6'd0;
                            r_last       <= 1'b1;
                        end else begin
                            r_status     <= ST_OK;
                            r_slot       <= n_slot;
                            r_write_flag <= (i_operation == OP_WRITE);
                            r_prd_count  <= n_prds[5:0];
                            r_fis_dword  <= FIS_LENGTH_DW;
                            r_last       <= 1'b0;
                            r_state      <= S_FIS;
                        end
                    end
                end
                S_FIS: begin
                    r_strobe      <= 1'b1;
                    r_kind        <= KIND_FIS;
                    r_fis_dword   <= n_dword;
                    r_prd_address <= 64'd0;
                    r_bm1         <= 12'd0;
                    r_fis_idx     <= r_fis_idx + 3'd1;
                    r_last        <= (r_fis_idx == FIS_LAST_DW) && (r_prd_count == 6'd0);
                    if (r_fis_idx == FIS_LAST_DW) begin
                        r_state <= (r_prd_count == 6'd0) ? S_IDLE : S_PRD;
                    end
                end
                S_PRD: begin
                    r_strobe      <= 1'b1;
                    r_kind        <= KIND_PRD;
                    r_fis_dword   <= 32'd0;
                    r_prd_address <= r_addr;
                    r_addr        <= r_addr + 64'(PRD_CHUNK_BYTES);
                    r_prd_idx     <= r_prd_idx + 6'd1;
                    r_last        <= n_prd_last;
                    if (n_prd_last) begin
                        // Final chunk holds whatever is left of the buffer.
                        r_bm1   <= 12'((r_bytes - BYTES_W'(1)) & CHUNK_M1);
                        r_state <= S_IDLE;
                    end else begin
                        r_bm1 <= 12'(CHUNK_M1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy                  = (r_state != S_IDLE);
    assign o_strobe              = r_strobe;
    assign o_status              = r_status;
    assign o_record_kind         = r_kind;
    assign o_slot                = r_slot;
    assign o_write_flag          = r_write_flag;
    assign o_prd_count           = r_prd_count;
    assign o_fis_dword           = r_fis_dword;
    assign o_prd_address         = r_prd_address;
    assign o_prd_bytes_minus_one = r_bm1;
    assign o_last                = r_last;

endmodule
